// File: rtl/sfrm_pkg.sv
// Shared types and constants of the sliding-window frame-rate meter.
// No dependencies; compile this file first.
package sfrm_pkg;

   // Width of the frame timestamp in microseconds.
   localparam int TS_W = 63;
   // Width of one slot counter and of the held count.
   localparam int COUNT_W = 16;
   // Width of the frames-per-second result.
   localparam int RESULT_W = 20;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

   typedef logic [TS_W-1:0] timestamp_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [RESULT_W-1:0] result_type;

endpackage

// File: rtl/sfrm_req_if.sv
// Valid/ready channel that carries one frame event word (its timestamp).
// Depends on sfrm_pkg.
interface sfrm_req_if
   import sfrm_pkg::*;
();
   logic valid;
   logic ready;
   timestamp_type timestamp_us;

   modport source (output valid, output timestamp_us, input ready);
   modport sink (input valid, input timestamp_us, output ready);
endinterface

// File: rtl/sfrm_rsp_if.sv
// Valid/ready channel that carries one frame-rate result word.
// Depends on sfrm_pkg.
interface sfrm_rsp_if
   import sfrm_pkg::*;
();
   logic valid;
   logic ready;
   result_type frames_last_second;

   modport source (output valid, output frames_last_second, input ready);
   modport sink (input valid, input frames_last_second, output ready);
endinterface

// File: rtl/sliding_window_frame_rate_meter.sv
// Top level of the sliding-window frame-rate meter.
// Depends on sfrm_pkg, sfrm_req_if and sfrm_rsp_if.

// The meter takes one frame event word per clock cycle and returns one result word per event,
// in order. A result word is presented from the output register, which follows the update stage.
// The slot of an event is floor(timestamp / SLOT_MICROSECONDS) modulo NUM_SLOTS, which equals
// the timestamp modulo the whole window (NUM_SLOTS * SLOT_MICROSECONDS) divided by
// SLOT_MICROSECONDS. That residue is formed without a divider: every timestamp bit carries a
// constant weight (its power of two modulo the window), the weights of the set bits are added
// over two stages (eight-bit groups first, then the group sums), the total is brought below
// the window by six compare-and-subtract steps spread over two more stages, and a fifth stage
// compares the residue with the slot boundaries. The slot counters live in a small synchronous
// memory; its read and the write-back form the last two stages, and the most recent
// write is forwarded to the next event so back-to-back events in the same slot see the updated
// count. A running total of all counters is kept in a register, so the result (all other slots
// plus the held count) needs no sweep of the memory: it equals the total minus the slot's old
// count plus the held count, saturated to 20 bits. Each counter has a valid bit that reset
// clears, so the block is ready right after reset with no clearing pass. The result side has
// an output register and a skid register; the pipeline freezes only while the skid register
// holds a word, so req_chan.ready does not depend on rsp_chan.ready. Outside of that stall
// and of reset, one event word can be taken every cycle.
module sliding_window_frame_rate_meter
   import sfrm_pkg::*;
#(
   parameter int NUM_SLOTS = 10,
   parameter int SLOT_MICROSECONDS = 100000
) (
   input logic clock,
   input logic reset,
   sfrm_req_if.sink req_chan,
   sfrm_rsp_if.source rsp_chan
);

   // Slot index width and running-total width.
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int TW = $clog2(NUM_SLOTS * 65535 + 1);
   localparam int CW = (TW > RESULT_W) ? TW : RESULT_W;
   localparam logic [SW:0] SLOT_NUM = (SW+1)'(NUM_SLOTS);
   // Length of the whole window in microseconds and the width of a residue below it. The
   // timestamp is cut into groups of eight bits; a group sum stays below eight windows and
   // the total below NB windows.
   localparam longint unsigned WIN_US = longint'(NUM_SLOTS) * longint'(SLOT_MICROSECONDS);
   localparam int MW = $clog2(WIN_US);
   localparam int GB = 8;
   localparam int NG = (TS_W + GB - 1) / GB;
   localparam int NB = NG * GB;
   localparam int LOG_NB = $clog2(NB);
   localparam int RED_SPLIT = LOG_NB / 2;
   localparam int GW = MW + $clog2(GB);
   localparam int AW = MW + LOG_NB;

   // Weight of each timestamp bit: two to the power of its position, modulo the window.
   function automatic logic [NB*MW-1:0] bit_weights();
      logic [NB*MW-1:0] tbl;
      logic [MW:0] w;
      tbl = '0;
      w = (MW+1)'(1);
      for (int i = 0; i < NB; i++) begin
         tbl[i*MW +: MW] = w[MW-1:0];
         w = w << 1;
         if (w >= (MW+1)'(WIN_US)) begin
            w = w - (MW+1)'(WIN_US);
         end
      end
      return tbl;
   endfunction

   localparam logic [NB*MW-1:0] BIT_WEIGHT = bit_weights();

   // ---------------------------------------------------------------------------------------
   // Pipeline enable: everything advances unless the skid register is occupied.
   // ---------------------------------------------------------------------------------------
   logic skid_vld_ff;
   logic en;

   assign en = !skid_vld_ff;
   assign req_chan.ready = en && !reset;

   // ---------------------------------------------------------------------------------------
   // Slot-index unit: weighted bit sum, two reduction stages and the boundary compare.
   // ---------------------------------------------------------------------------------------
   logic [GW-1:0] grp_ff [NG];
   logic [GW-1:0] grp_in [NG];
   logic [AW-1:0] sum_ff;
   logic [AW-1:0] sum_in;
   logic [AW-1:0] part_ff;
   logic [AW-1:0] part_in;
   logic [MW-1:0] win_rem_ff;
   logic [MW-1:0] win_rem_in;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] slot_in;
   logic [4:0] vld_ff;
   logic [4:0] vld_in;

   // Each group adds the weights of its set bits.
   always_comb begin
      logic [NB-1:0] ts_ext;
      ts_ext = NB'(req_chan.timestamp_us);
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < GB; b++) begin
            if (ts_ext[g*GB + b]) begin
               grp_in[g] = grp_in[g] + GW'(BIT_WEIGHT[(g*GB + b)*MW +: MW]);
            end
         end
      end
   end

   always_comb begin
      logic [AW-1:0] acc;
      acc = '0;
      for (int g = 0; g < NG; g++) begin
         acc = acc + AW'(grp_ff[g]);
      end
      sum_in = acc;
   end

   // The total is below NB windows; halving steps of the window bring it below one window.
   always_comb begin
      logic [AW-1:0] x;
      x = sum_ff;
      for (int j = LOG_NB - 1; j >= RED_SPLIT; j--) begin
         if (x >= AW'(WIN_US << j)) begin
            x = x - AW'(WIN_US << j);
         end
      end
      part_in = x;
   end

   always_comb begin
      logic [AW-1:0] x;
      x = part_ff;
      for (int j = RED_SPLIT - 1; j >= 0; j--) begin
         if (x >= AW'(WIN_US << j)) begin
            x = x - AW'(WIN_US << j);
         end
      end
      win_rem_in = x[MW-1:0];
   end

   // The slot is the number of slot boundaries at or below the residue.
   always_comb begin
      slot_in = '0;
      for (int k = 1; k < NUM_SLOTS; k++) begin
         if (win_rem_ff >= MW'(longint'(k) * longint'(SLOT_MICROSECONDS))) begin
            slot_in = SW'(k);
         end
      end
   end

   assign vld_in = {vld_ff[3:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < NG; g++) begin
            grp_ff[g] <= grp_in[g];
         end
         sum_ff <= sum_in;
         part_ff <= part_in;
         win_rem_ff <= win_rem_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Slot counter memory. The read is issued from the slot stage; the write-back happens
   // from the update stage, which takes the read data register.
   // ---------------------------------------------------------------------------------------
   count_type cnt_mem [NUM_SLOTS];
   count_type rd_data_ff;
   logic [SW-1:0] slot_b_ff;
   logic vld_b_ff;
   logic [NUM_SLOTS-1:0] cnt_vld_ff;
   logic [SW-1:0] wr_addr_ff;
   count_type wr_data_ff;
   logic wr_vld_ff;
   logic wr_en;
   count_type old_cnt;
   count_type new_cnt;

   assign wr_en = en && vld_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= cnt_mem[slot_ff];
         slot_b_ff <= slot_ff;
      end
      if (wr_en) begin
         cnt_mem[slot_b_ff] <= new_cnt;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Update stage: old count (forwarded, memory or cleared), new count, held count, total.
   // ---------------------------------------------------------------------------------------
   logic [SW-1:0] prev_slot_ff;
   count_type held_ff;
   count_type held_in;
   logic [TW-1:0] total_ff;
   logic [TW-1:0] total_in;
   logic slot_changed;
   logic [TW-1:0] res_wide;
   result_type res_in;

   always_comb begin
      // The previous event's write landed after this event's read, so take it from the
      // write register; an entry never written since reset reads as zero.
      if (wr_vld_ff && (wr_addr_ff == slot_b_ff)) begin
         old_cnt = wr_data_ff;
      end else if (cnt_vld_ff[slot_b_ff]) begin
         old_cnt = rd_data_ff;
      end else begin
         old_cnt = '0;
      end
      slot_changed = (slot_b_ff != prev_slot_ff);
      if (slot_changed) begin
         new_cnt = count_type'(1);
         held_in = old_cnt;
      end else begin
         new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + count_type'(1);
         held_in = held_ff;
      end
      total_in = total_ff - TW'(old_cnt) + TW'(new_cnt);
      // Other slots plus held count: the total without this slot's old count.
      res_wide = total_ff - TW'(old_cnt) + TW'(held_in);
      if (CW'(res_wide) > CW'(RESULT_MAX)) begin
         res_in = RESULT_MAX;
      end else begin
         res_in = RESULT_W'(res_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
         cnt_vld_ff <= '0;
         wr_vld_ff <= 1'b0;
         prev_slot_ff <= '0;
         held_ff <= '0;
         total_ff <= '0;
      end else begin
         if (en) begin
            vld_b_ff <= vld_ff[4];
         end
         if (wr_en) begin
            cnt_vld_ff[slot_b_ff] <= 1'b1;
            wr_vld_ff <= 1'b1;
            prev_slot_ff <= slot_b_ff;
            held_ff <= held_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_addr_ff <= slot_b_ff;
         wr_data_ff <= new_cnt;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side: output register plus skid register.
   // ---------------------------------------------------------------------------------------
   logic out_vld_ff;
   result_type out_data_ff;
   result_type skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         priority if (skid_vld_ff) begin
            if (rsp_chan.ready) begin
               skid_vld_ff <= 1'b0;
            end
         end else if (wr_en) begin
            if (!out_vld_ff || rsp_chan.ready) begin
               out_vld_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= out_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_vld_ff) begin
         if (rsp_chan.ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (wr_en) begin
         if (!out_vld_ff || rsp_chan.ready) begin
            out_data_ff <= res_in;
         end else begin
            skid_data_ff <= res_in;
         end
      end else begin
         out_data_ff <= out_data_ff;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.frames_last_second = out_data_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a word while the output register is empty");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (wr_en && out_vld_ff && !rsp_chan.ready) |=> (skid_vld_ff && out_vld_ff))
      else $error("result produced under a stalled output was dropped");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_b_ff |-> ({1'b0, slot_b_ff} < SLOT_NUM))
      else $error("slot index out of range");

   a_written_slot_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (cnt_vld_ff[wr_addr_ff] && wr_vld_ff))
      else $error("written slot not marked valid");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (TW'(old_cnt) <= total_ff))
      else $error("running total smaller than a slot count");

endmodule
